FILE: sv/sspc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the serial setpoint command parser
package sspc_pkg;

	localparam int MAX_LINE = 16;
	localparam int POS_W    = $clog2(MAX_LINE + 1);

	localparam int FS_W    = 18;
	localparam int LIM_W   = 10;
	localparam int VAL_W   = 11;
	localparam int PROD_W  = LIM_W + FS_W;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [FS_W-1:0]   RESET_FULL_SCALE = FS_W'(169706);
	localparam logic [LIM_W-1:0]  RESET_LIMIT      = LIM_W'(1000);
	localparam logic [VAL_W-1:0]  NUM_SAT          = {VAL_W{1'b1}};
	localparam logic [PROD_W-1:0] DRIVE_MAX        = PROD_W'({FS_W{1'b1}});

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_V     = 8'h56;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [0:0] {
		REG_FULL_SCALE     = 1'b0,
		REG_SETPOINT_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		BIT_INVALID = 2'd0,
		BIT_ZERO    = 2'd1,
		BIT_ONE     = 2'd2,
		BIT_PENDING = 2'd3
	} bit_code_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [FS_W-1:0]  drive_mv;
		logic             reply_enable;
		logic [LIM_W-1:0] reply_setpoint;
		logic             led_enable;
		logic             led_write;
		logic             parse_error;
	} out_t;

	typedef struct packed {
		logic byte_en;
		logic line_en;
		logic mul_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

FILE: sv/serial_setpoint_command_parser_core.sv
`timescale 1ns / 1ps
// top level of the serial setpoint command parser with its configuration registers
// Takes one byte of a command line (S<0|1>, V<number>, L<0|1>) per item and a closing
// end-of-line item. A byte item is taken while the sequencer is idle and gives no result.
// An end-of-line item commits the settings at the edge that takes it and then gives one
// result: the MUL state forms setpoint*full_scale in a 10x18 multiplier, the DIV state runs
// a restoring divider that produces one quotient bit a cycle against setpoint_limit, and
// the DONE state loads the result register once it is free. No item is taken during that
// work, which lasts longer while the previous result still waits for out_ready; a
// finished result may wait in its register while the next line is received.
// Registers: full_scale_mv at 0x0, setpoint_limit at 0x4.
module serial_setpoint_command_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sspc_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sspc_pkg::out_t                out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sspc_pkg::ADDR_W-1:0]   paddr,
	input  logic [sspc_pkg::DATA_W-1:0]   pwdata,
	output logic [sspc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [sspc_pkg::FS_W-1:0]  full_scale_q;
	logic [sspc_pkg::LIM_W-1:0] limit_q;
	sspc_pkg::reg_idx_t         reg_idx;
	sspc_pkg::cmd_t             cmd;
	sspc_pkg::status_t          st;

	assign pready  = 1'b1;
	assign reg_idx = sspc_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= sspc_pkg::RESET_FULL_SCALE;
			limit_q      <= sspc_pkg::RESET_LIMIT;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				sspc_pkg::REG_FULL_SCALE:     full_scale_q <= pwdata[sspc_pkg::FS_W-1:0];
				sspc_pkg::REG_SETPOINT_LIMIT: limit_q      <= pwdata[sspc_pkg::LIM_W-1:0];
				default: begin
					full_scale_q <= full_scale_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sspc_pkg::REG_FULL_SCALE:     prdata = sspc_pkg::DATA_W'(full_scale_q);
			sspc_pkg::REG_SETPOINT_LIMIT: prdata = sspc_pkg::DATA_W'(limit_q);
			default:                      prdata = '0;
		endcase
	end

	sspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.line_end  (in_data.line_end),
		.out_ready (out_ready),
		.st        (st),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sspc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rx_byte    (in_data.rx_byte),
		.full_scale (full_scale_q),
		.limit      (limit_q),
		.st         (st),
		.out_data   (out_data)
	);

endmodule

FILE: sv/sspc_datapath.sv
`timescale 1ns / 1ps
// parse state, commit logic, scaling multiplier, serial divider and result register
module sspc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sspc_pkg::cmd_t                cmd,
	input  logic [7:0]                    rx_byte,
	input  logic [sspc_pkg::FS_W-1:0]     full_scale,
	input  logic [sspc_pkg::LIM_W-1:0]    limit,
	output sspc_pkg::status_t             st,
	output sspc_pkg::out_t                out_data
);

	// stored settings
	logic                         en_q, led_q;
	logic [sspc_pkg::LIM_W-1:0]   sp_q;
	// per-line parse state
	logic [sspc_pkg::POS_W-1:0]   pos_q;
	logic                         fs_q, fv_q, fl_q, first_q, ovf_q;
	sspc_pkg::bit_code_t          sw_q, lv_q;
	sspc_pkg::phase_t             ph_q;
	logic                         neg_q;
	logic [sspc_pkg::VAL_W-1:0]   val_q;
	// result of the commit
	logic                         res_ok_q, res_ledw_q, res_err_q;
	// multiply and divide
	logic [sspc_pkg::PROD_W-1:0]  quo_q;
	logic [sspc_pkg::LIM_W-1:0]   rem_q;
	logic [sspc_pkg::CNT_W-1:0]   cnt_q;
	sspc_pkg::out_t               out_q;

	// next values of the byte step
	sspc_pkg::bit_code_t          sw_n, lv_n;
	sspc_pkg::phase_t             ph_n;
	logic                         neg_n, first_n;
	logic [sspc_pkg::VAL_W-1:0]   val_n;
	logic [sspc_pkg::VAL_W+3:0]   acc;
	logic                         is_digit, is_space;

	// commit values
	logic                         err_s, err_l, err_v;
	logic                         en_c, led_c;
	logic [sspc_pkg::LIM_W-1:0]   sp_c;

	logic [sspc_pkg::LIM_W:0]     trial;
	logic                         trial_ge;
	logic [sspc_pkg::PROD_W-1:0]  drive_wide;

	function automatic sspc_pkg::bit_code_t resolve(input sspc_pkg::bit_code_t code,
		input logic [7:0] c);
		sspc_pkg::bit_code_t r;
		r = code;
		if (code == sspc_pkg::BIT_PENDING) begin
			if (c == sspc_pkg::CH_0)
				r = sspc_pkg::BIT_ZERO;
			else if (c == sspc_pkg::CH_1)
				r = sspc_pkg::BIT_ONE;
			else
				r = sspc_pkg::BIT_INVALID;
		end
		return r;
	endfunction

	assign is_digit = (rx_byte >= sspc_pkg::CH_0) && (rx_byte <= sspc_pkg::CH_9);
	assign is_space = (rx_byte == sspc_pkg::CH_SPACE) ||
		((rx_byte >= sspc_pkg::CH_TAB) && (rx_byte <= sspc_pkg::CH_CR));
	assign acc = ({val_q, 3'b000} + {2'b00, val_q, 1'b0}) +
		(sspc_pkg::VAL_W + 4)'(rx_byte[3:0]);

	always_comb begin
		sw_n    = resolve(sw_q, rx_byte);
		lv_n    = resolve(lv_q, rx_byte);
		ph_n    = ph_q;
		neg_n   = neg_q;
		val_n   = val_q;
		first_n = first_q;
		if (rx_byte == sspc_pkg::CH_S) begin
			sw_n = sspc_pkg::BIT_PENDING;
			ph_n = sspc_pkg::PH_DONE;
		end else if (rx_byte == sspc_pkg::CH_L) begin
			lv_n = sspc_pkg::BIT_PENDING;
			ph_n = sspc_pkg::PH_DONE;
		end else if (rx_byte == sspc_pkg::CH_V) begin
			ph_n  = sspc_pkg::PH_SKIP;
			neg_n = 1'b0;
			val_n = '0;
		end else begin
			if (pos_q == '0)
				first_n = 1'b1;
			if (fv_q) begin
				if (ph_q == sspc_pkg::PH_SKIP && is_space) begin
					ph_n = ph_q;
				end else if (ph_q == sspc_pkg::PH_SKIP &&
					(rx_byte == sspc_pkg::CH_PLUS || rx_byte == sspc_pkg::CH_MINUS)) begin
					neg_n = (rx_byte == sspc_pkg::CH_MINUS);
					ph_n  = sspc_pkg::PH_SIGN;
				end else if (ph_q != sspc_pkg::PH_DONE) begin
					if (is_digit) begin
						// saturating decimal accumulate
						val_n = (acc > (sspc_pkg::VAL_W + 4)'(sspc_pkg::NUM_SAT)) ?
							sspc_pkg::NUM_SAT : acc[sspc_pkg::VAL_W-1:0];
						ph_n  = sspc_pkg::PH_DIGITS;
					end else begin
						ph_n = sspc_pkg::PH_DONE;
					end
				end
			end
		end
	end

	// end-of-line commit: S, then L, then V, first error stops the rest
	always_comb begin
		en_c  = en_q;
		led_c = led_q;
		sp_c  = sp_q;
		err_s = first_q | ovf_q;
		if (!err_s && fs_q) begin
			if (sw_q == sspc_pkg::BIT_ZERO)
				en_c = 1'b0;
			else if (sw_q == sspc_pkg::BIT_ONE)
				en_c = 1'b1;
			else
				err_s = 1'b1;
		end
		err_l = err_s;
		if (!err_l && fl_q) begin
			if (lv_q == sspc_pkg::BIT_ZERO)
				led_c = 1'b0;
			else if (lv_q == sspc_pkg::BIT_ONE)
				led_c = 1'b1;
			else
				err_l = 1'b1;
		end
		err_v = err_l;
		if (!err_v && fv_q) begin
			if ((neg_q && val_q != '0) || (val_q > {1'b0, limit}))
				err_v = 1'b1;
			else
				sp_c = val_q[sspc_pkg::LIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			led_q   <= 1'b0;
			sp_q    <= '0;
			pos_q   <= '0;
			fs_q    <= 1'b0;
			fv_q    <= 1'b0;
			fl_q    <= 1'b0;
			first_q <= 1'b0;
			ovf_q   <= 1'b0;
			sw_q    <= sspc_pkg::BIT_INVALID;
			lv_q    <= sspc_pkg::BIT_INVALID;
			ph_q    <= sspc_pkg::PH_SKIP;
			neg_q   <= 1'b0;
			val_q   <= '0;
		end else if (cmd.byte_en) begin
			if (pos_q >= sspc_pkg::POS_W'(sspc_pkg::MAX_LINE)) begin
				ovf_q <= 1'b1;
			end else begin
				pos_q   <= pos_q + 1'b1;
				sw_q    <= sw_n;
				lv_q    <= lv_n;
				ph_q    <= ph_n;
				neg_q   <= neg_n;
				val_q   <= val_n;
				first_q <= first_n;
				if (rx_byte == sspc_pkg::CH_S)
					fs_q <= 1'b1;
				if (rx_byte == sspc_pkg::CH_V)
					fv_q <= 1'b1;
				if (rx_byte == sspc_pkg::CH_L)
					fl_q <= 1'b1;
			end
		end else if (cmd.line_en) begin
			en_q    <= en_c;
			led_q   <= led_c;
			sp_q    <= sp_c;
			pos_q   <= '0;
			fs_q    <= 1'b0;
			fv_q    <= 1'b0;
			fl_q    <= 1'b0;
			first_q <= 1'b0;
			ovf_q   <= 1'b0;
			sw_q    <= sspc_pkg::BIT_INVALID;
			lv_q    <= sspc_pkg::BIT_INVALID;
			ph_q    <= sspc_pkg::PH_SKIP;
			neg_q   <= 1'b0;
			val_q   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.line_en) begin
			res_ok_q   <= !err_v && en_c;
			res_ledw_q <= !err_v && fl_q;
			res_err_q  <= err_v;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial    = {rem_q, quo_q[sspc_pkg::PROD_W-1]};
	assign trial_ge = trial >= {1'b0, limit};

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			quo_q <= sspc_pkg::PROD_W'(sp_q) * sspc_pkg::PROD_W'(full_scale);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? sspc_pkg::LIM_W'(trial - {1'b0, limit}) :
				trial[sspc_pkg::LIM_W-1:0];
			quo_q <= {quo_q[sspc_pkg::PROD_W-2:0], trial_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign st.div_last = (cnt_q == sspc_pkg::CNT_W'(sspc_pkg::PROD_W - 1));

	assign drive_wide = (quo_q > sspc_pkg::DRIVE_MAX) ? sspc_pkg::DRIVE_MAX : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.drive_mv       <= (res_ok_q && limit != '0) ?
				drive_wide[sspc_pkg::FS_W-1:0] : '0;
			out_q.reply_enable   <= res_ok_q;
			out_q.reply_setpoint <= res_ok_q ? sp_q : '0;
			out_q.led_enable     <= led_q;
			out_q.led_write      <= res_ledw_q;
			out_q.parse_error    <= res_err_q;
		end
	end

	assign out_data = out_q;

endmodule

FILE: sv/sspc_ctrl.sv
`timescale 1ns / 1ps
// sequencer: item intake, multiply, divide and result hand-off
module sspc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              line_end,
	input  logic              out_ready,
	input  sspc_pkg::status_t st,
	output logic              in_ready,
	output logic              out_valid,
	output sspc_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.byte_en = !line_end;
					cmd.line_en = line_end;
					if (line_end)
						state_n = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_n       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last)
					state_n = ST_DONE;
			end
			ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_line_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && line_end) |=> !in_ready)
		else $error("item taken during end-of-line work");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without finished division");

	a_done_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not handed off");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the serial setpoint command parser core
module tb;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	sspc_pkg::in_t               in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	sspc_pkg::out_t              out_data;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [sspc_pkg::ADDR_W-1:0] paddr     = '0;
	logic [sspc_pkg::DATA_W-1:0] pwdata    = '0;
	logic [sspc_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	serial_setpoint_command_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state as the testbench sees it
	logic [sspc_pkg::FS_W-1:0]  cfg_full_scale = sspc_pkg::RESET_FULL_SCALE;
	logic [sspc_pkg::LIM_W-1:0] cfg_limit      = sspc_pkg::RESET_LIMIT;
	logic                       out_on         = 1'b0;
	logic [sspc_pkg::LIM_W-1:0] held_setpoint  = '0;
	logic                       led_on         = 1'b0;
	int unsigned                line_pos       = 0;
	logic                       saw_s          = 1'b0;
	logic                       saw_v          = 1'b0;
	logic                       saw_l          = 1'b0;
	logic                       bad_first      = 1'b0;
	logic                       too_long       = 1'b0;
	sspc_pkg::bit_code_t        sw_code        = sspc_pkg::BIT_INVALID;
	sspc_pkg::bit_code_t        led_code       = sspc_pkg::BIT_INVALID;
	sspc_pkg::phase_t           num_phase      = sspc_pkg::PH_SKIP;
	logic                       num_neg        = 1'b0;
	logic [sspc_pkg::VAL_W-1:0] num_val        = '0;

	sspc_pkg::out_t expected_replies[$];
	sspc_pkg::in_t  pending_items[$];
	logic [7:0]     line_bytes[$];
	int unsigned    items_queued = 0;
	int unsigned    fail_count   = 0;

	int unsigned send_gap   = 0;
	int unsigned send_burst = 0;
	int unsigned rx_cycles  = 0;
	int unsigned rx_hold    = 0;
	int unsigned rx_seg     = 0;
	int unsigned rx_mode    = 0;

	function automatic sspc_pkg::bit_code_t settle_digit(sspc_pkg::bit_code_t pend,
		logic [7:0] c);
		if (pend != sspc_pkg::BIT_PENDING)
			return pend;
		if (c == sspc_pkg::CH_0)
			return sspc_pkg::BIT_ZERO;
		if (c == sspc_pkg::CH_1)
			return sspc_pkg::BIT_ONE;
		return sspc_pkg::BIT_INVALID;
	endfunction

	task automatic predict_item(sspc_pkg::in_t it);
		logic [7:0]     c;
		logic           err;
		logic           is_space;
		logic [63:0]    drive;
		int unsigned    digit_sum;
		sspc_pkg::out_t r;
		c = it.rx_byte;
		is_space = (c == sspc_pkg::CH_SPACE) ||
			(c >= sspc_pkg::CH_TAB && c <= sspc_pkg::CH_CR);
		if (!it.line_end) begin
			if (line_pos >= sspc_pkg::MAX_LINE) begin
				too_long = 1'b1;
			end else begin
				sw_code = settle_digit(sw_code, c);
				led_code = settle_digit(led_code, c);
				if (c == sspc_pkg::CH_S) begin
					saw_s = 1'b1;
					sw_code = sspc_pkg::BIT_PENDING;
					num_phase = sspc_pkg::PH_DONE;
				end else if (c == sspc_pkg::CH_L) begin
					saw_l = 1'b1;
					led_code = sspc_pkg::BIT_PENDING;
					num_phase = sspc_pkg::PH_DONE;
				end else if (c == sspc_pkg::CH_V) begin
					saw_v = 1'b1;
					num_phase = sspc_pkg::PH_SKIP;
					num_neg = 1'b0;
					num_val = '0;
				end else begin
					if (line_pos == 0)
						bad_first = 1'b1;
					if (saw_v) begin
						if (num_phase == sspc_pkg::PH_SKIP &&
								(c == sspc_pkg::CH_PLUS || c == sspc_pkg::CH_MINUS)) begin
							num_neg = (c == sspc_pkg::CH_MINUS);
							num_phase = sspc_pkg::PH_SIGN;
						end else if (!(num_phase == sspc_pkg::PH_SKIP && is_space) &&
								num_phase != sspc_pkg::PH_DONE) begin
							if (c >= sspc_pkg::CH_0 && c <= sspc_pkg::CH_9) begin
								digit_sum = num_val * 10 + (c - sspc_pkg::CH_0);
								num_val = (digit_sum > sspc_pkg::NUM_SAT) ?
									sspc_pkg::NUM_SAT : sspc_pkg::VAL_W'(digit_sum);
								num_phase = sspc_pkg::PH_DIGITS;
							end else begin
								num_phase = sspc_pkg::PH_DONE;
							end
						end
					end
				end
				line_pos++;
			end
		end else begin
			// commit order is S, L, V and the first error stops the rest
			err = bad_first | too_long;
			if (!err && saw_s) begin
				case (sw_code)
					sspc_pkg::BIT_ZERO: out_on = 1'b0;
					sspc_pkg::BIT_ONE:  out_on = 1'b1;
					default:            err = 1'b1;
				endcase
			end
			if (!err && saw_l) begin
				case (led_code)
					sspc_pkg::BIT_ZERO: led_on = 1'b0;
					sspc_pkg::BIT_ONE:  led_on = 1'b1;
					default:            err = 1'b1;
				endcase
			end
			if (!err && saw_v) begin
				if ((num_neg && num_val != 0) || num_val > cfg_limit)
					err = 1'b1;
				else
					held_setpoint = num_val[sspc_pkg::LIM_W-1:0];
			end
			drive = '0;
			if (!err && out_on && cfg_limit != 0) begin
				drive = (64'(held_setpoint) * 64'(cfg_full_scale)) / 64'(cfg_limit);
				if (drive > sspc_pkg::DRIVE_MAX)
					drive = sspc_pkg::DRIVE_MAX;
			end
			r.drive_mv       = drive[sspc_pkg::FS_W-1:0];
			r.reply_enable   = !err && out_on;
			r.reply_setpoint = (!err && out_on) ? held_setpoint : '0;
			r.led_enable     = led_on;
			r.led_write      = !err && saw_l;
			r.parse_error    = err;
			expected_replies.push_back(r);
			line_pos  = 0;
			saw_s     = 1'b0;
			saw_v     = 1'b0;
			saw_l     = 1'b0;
			bad_first = 1'b0;
			too_long  = 1'b0;
			sw_code   = sspc_pkg::BIT_INVALID;
			led_code  = sspc_pkg::BIT_INVALID;
			num_phase = sspc_pkg::PH_SKIP;
			num_neg   = 1'b0;
			num_val   = '0;
		end
	endtask

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// driver: bursts of items from the pending queue with random gaps
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (send_gap > 0 || pending_items.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				in_valid <= 1'b0;
			end else begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (send_burst > 0) begin
					send_burst--;
				end else begin
					send_burst = $urandom_range(0, 40);
					case ($urandom_range(0, 7))
						0, 1:    send_gap = 0;
						2:       send_gap = $urandom_range(13, 40);
						default: send_gap = $urandom_range(1, 12);
					endcase
				end
			end
		end
	end

	// receiver: random stall pattern plus a long hold-off now and then
	always @(posedge clk) begin
		rx_cycles++;
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_cycles % 3000 == 1500) begin
			rx_hold = 400;
			out_ready <= 1'b0;
		end else begin
			if (rx_seg == 0) begin
				rx_seg = $urandom_range(1, 60);
				rx_mode = $urandom_range(0, 2);
			end else begin
				rx_seg--;
			end
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: check results first, then predict from the accepted item
	always @(posedge clk) begin : monitor_blk
		sspc_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, out_data);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					check_field("drive_mv", want.drive_mv, out_data.drive_mv);
					check_field("reply_enable", want.reply_enable, out_data.reply_enable);
					check_field("reply_setpoint", want.reply_setpoint, out_data.reply_setpoint);
					check_field("led_enable", want.led_enable, out_data.led_enable);
					check_field("led_write", want.led_write, out_data.led_write);
					check_field("parse_error", want.parse_error, out_data.parse_error);
				end
			end
			if (in_valid && in_ready)
				predict_item(in_data);
		end
	end

	task automatic cfg_write(sspc_pkg::reg_idx_t idx, logic [sspc_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sspc_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(logic [sspc_pkg::FS_W-1:0] fs, logic [sspc_pkg::LIM_W-1:0] lim);
		cfg_write(sspc_pkg::REG_FULL_SCALE, sspc_pkg::DATA_W'(fs));
		cfg_write(sspc_pkg::REG_SETPOINT_LIMIT, sspc_pkg::DATA_W'(lim));
		cfg_full_scale = fs;
		cfg_limit = lim;
	endtask

	// wait until every item is taken and every result is back, then let the bench idle
	task automatic settle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_replies.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	// queue the collected bytes and close the line
	task automatic push_line();
		sspc_pkg::in_t it;
		foreach (line_bytes[i]) begin
			it.rx_byte = line_bytes[i];
			it.line_end = 1'b0;
			pending_items.push_back(it);
		end
		it.rx_byte = 8'($urandom_range(0, 255));
		it.line_end = 1'b1;
		pending_items.push_back(it);
		items_queued += line_bytes.size() + 1;
		line_bytes.delete();
	endtask

	task automatic add_switch(logic [7:0] letter);
		int pick;
		line_bytes.push_back(letter);
		pick = $urandom_range(0, 19);
		if (pick < 9)
			line_bytes.push_back(sspc_pkg::CH_0);
		else if (pick < 18)
			line_bytes.push_back(sspc_pkg::CH_1);
		else if (pick == 18)
			line_bytes.push_back(8'($urandom_range(0, 255)));
		// otherwise the letter stands bare
	endtask

	task automatic add_number();
		int unsigned n;
		int pick;
		line_bytes.push_back(sspc_pkg::CH_V);
		if ($urandom_range(0, 4) == 0)
			line_bytes.push_back($urandom_range(0, 1) ? sspc_pkg::CH_SPACE :
				8'($urandom_range(9, 13)));
		pick = $urandom_range(0, 5);
		if (pick == 0)
			line_bytes.push_back(sspc_pkg::CH_PLUS);
		else if (pick == 1)
			line_bytes.push_back(sspc_pkg::CH_MINUS);
		case ($urandom_range(0, 7))
			0:       n = 0;
			1:       n = cfg_limit;
			2:       n = cfg_limit + 1;
			3:       n = $urandom_range(0, 2047);
			4:       n = $urandom_range(2048, 999999);
			default: n = $urandom_range(0, cfg_limit);
		endcase
		if ($urandom_range(0, 7) == 0)
			line_bytes.push_back(sspc_pkg::CH_0);
		if ($urandom_range(0, 9) != 0)
			add_text($sformatf("%0d", n));
	endtask

	task automatic gen_line();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 2))
					0:       add_switch(sspc_pkg::CH_S);
					1:       add_switch(sspc_pkg::CH_L);
					default: add_number();
				endcase
			end
			// broken line: one byte replaced by noise
			if (kind >= 75) begin
				pos = $urandom_range(0, line_bytes.size() - 1);
				line_bytes[pos] = 8'($urandom_range(0, 255));
			end
		end else if (kind < 93) begin
			repeat ($urandom_range(1, 20))
				line_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 97) begin
			while (line_bytes.size() <= sspc_pkg::MAX_LINE)
				add_number();
		end
		// the rest are empty lines
		push_line();
	endtask

	initial begin
		int unsigned target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(sspc_pkg::RESET_FULL_SCALE, sspc_pkg::RESET_LIMIT);

		push_line();
		add_text("S1V1000");
		push_line();
		add_text("LS");
		push_line();
		add_text("x");
		push_line();
		add_text("V -7");
		push_line();
		add_text("L1V2000");
		push_line();
		settle();

		// stored setpoint above the new limit drives the quotient into saturation
		set_config({sspc_pkg::FS_W{1'b1}}, sspc_pkg::LIM_W'(1));
		push_line();
		settle();

		set_config(sspc_pkg::FS_W'(123456), '0);
		push_line();
		add_text("V0");
		push_line();
		add_text("V1");
		push_line();
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1:       set_config({sspc_pkg::FS_W{1'b1}}, {sspc_pkg::LIM_W{1'b1}});
				2:       set_config('0, sspc_pkg::LIM_W'(1));
				3:       set_config(sspc_pkg::FS_W'($urandom_range(0, 262143)),
						{sspc_pkg::LIM_W{1'b1}});
				default: set_config(sspc_pkg::FS_W'($urandom_range(0, 262143)),
						sspc_pkg::LIM_W'($urandom_range(1, 1023)));
			endcase
			target = items_queued + 255;
			while (items_queued < target)
				gen_line();
			settle();
		end

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
